FILE: rtl/assert_macros.svh
// Assertion macros used by rotate_first_trajectory_cost.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define RFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition is followed by another in the next cycle.
`define RFC_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");

`endif

FILE: rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and constants
// Widths, codes, the arctangent table and the pipeline records.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int STAGE_W       = 5;
    localparam int XW            = 56;
    localparam int ZW            = 34;
    localparam int DEN_W         = 17;
    localparam int NUM_W         = 43;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_SCORED = 2'd2;
    localparam logic [1:0] ST_NOPOSE = 2'd3;

    localparam logic [2:0] CFG_ANGLE_LIMIT = 3'd0;
    localparam logic [2:0] CFG_NEAR_DIST   = 3'd1;
    localparam logic [2:0] CFG_MAX_FWD     = 3'd2;
    localparam logic [2:0] CFG_COST_GAIN   = 3'd3;
    localparam logic [2:0] CFG_TURN_BIAS   = 3'd4;

    localparam logic signed [ZW-1:0] PI_Q30     = 34'sd3373259426;
    localparam logic signed [18:0]   PI_Q13     = 19'sd25736;
    localparam logic signed [18:0]   TWO_PI_Q13 = 19'sd51472;

    typedef struct packed {
        logic               valid;
        logic               bad;
        logic               in_range;
        logic [30:0]        ex;
        logic [30:0]        ey;
        logic signed [15:0] yaw;
        logic signed [15:0] fwd;
        logic signed [15:0] turn;
        logic signed [15:0] err;
        logic [1:0]         status;
    } t_side;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num;
    } t_div;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [STAGE_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/rfc_cordic_cell.sv
// ----------------------------------------------------------------------------
// rfc_cordic_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis by one table angle and passes it on.
// ----------------------------------------------------------------------------
module rfc_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [rfc_pkg::STAGE_W-1:0]  i_stage,
    input  rfc_pkg::t_side               i_side,
    input  rfc_pkg::t_cordic             i_cor,
    output rfc_pkg::t_side               o_side,
    output rfc_pkg::t_cordic             o_cor
);

    rfc_pkg::t_side   r_side;
    rfc_pkg::t_cordic r_cor;
    rfc_pkg::t_cordic n_cor;
    logic signed [rfc_pkg::XW-1:0] xs;
    logic signed [rfc_pkg::XW-1:0] ys;

    always_comb begin
        xs = i_cor.x >>> i_stage;
        ys = i_cor.y >>> i_stage;
        if (i_cor.y >= 0) begin
            n_cor.x = i_cor.x + ys;
            n_cor.y = i_cor.y - xs;
            n_cor.z = i_cor.z + rfc_pkg::atan_q30(i_stage);
        end else begin
            n_cor.x = i_cor.x - ys;
            n_cor.y = i_cor.y + xs;
            n_cor.z = i_cor.z - rfc_pkg::atan_q30(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cor <= n_cor;
        end
    end

    assign o_side = r_side;
    assign o_cor  = r_cor;

endmodule

FILE: rtl/rfc_div_cell.sv
// ----------------------------------------------------------------------------
// rfc_div_cell: one restoring division step
// Brings down one dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module rfc_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  rfc_pkg::t_side  i_side,
    input  rfc_pkg::t_div   i_div,
    output rfc_pkg::t_side  o_side,
    output rfc_pkg::t_div   o_div
);

    rfc_pkg::t_side r_side;
    rfc_pkg::t_div  r_div;
    rfc_pkg::t_div  n_div;
    logic [rfc_pkg::DEN_W:0] trial;
    logic                    fits;

    always_comb begin
        trial = {i_div.rem, i_div.num[rfc_pkg::NUM_W-1]};
        fits  = trial >= {1'b0, i_div.den};
        n_div.den = i_div.den;
        n_div.num = {i_div.num[rfc_pkg::NUM_W-2:0], fits};
        if (fits) begin
            n_div.rem = rfc_pkg::DEN_W'(trial - {1'b0, i_div.den});
        end else begin
            n_div.rem = rfc_pkg::DEN_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_side = r_side;
    assign o_div  = r_div;

endmodule

FILE: rtl/rotate_first_trajectory_cost.sv
// ----------------------------------------------------------------------------
// rotate_first_trajectory_cost: rotate-first trajectory scoring
// Path heading by CORDIC, heading error, turn-in-place test and cost divide.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// s_axis   in         s_axis_tvalid/tready   tuser pose_valid, tdata pose+path+speeds
// m_axis   out        m_axis_tvalid/tready   tdata status, cost, heading_error
// cfg      in         i_cfg_valid/o_cfg_ready index, data
//
// One item is accepted per cycle while the pipeline is not held. Each item passes
// the input stage, the CORDIC cell chain, the heading error and decision stages,
// the 43 cell division chain and the output register. Reset clears all stage valid flags and loads register defaults.
// The whole pipeline holds while a result waits at the output and
// m_axis_tready is low; otherwise it advances and accepts freely.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotate_first_trajectory_cost (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // robot_x, robot_y, robot_yaw, start_x, start_y, next_x, next_y,
    // fwd_speed, turn_rate
    input  logic [239:0] s_axis_tdata,
    // pose_valid
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, cost, heading_error, zero fill
    output logic [55:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int CS = rfc_pkg::CORDIC_STAGES;
    localparam int DS = rfc_pkg::NUM_W;

    logic [14:0] r_angle_limit;
    logic [30:0] r_near_dist;
    logic [14:0] r_max_fwd;
    logic [30:0] r_cost_gain;
    logic [14:0] r_turn_bias;

    logic en;
    logic r_out_valid;
    logic [55:0] r_out_data;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;
    assign o_cfg_ready   = i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_limit <= 15'd16384;
            r_near_dist   <= 31'd13107;
            r_max_fwd     <= 15'd287;
            r_cost_gain   <= 31'd655360;
            r_turn_bias   <= 15'd819;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rfc_pkg::CFG_ANGLE_LIMIT: r_angle_limit <= i_cfg_data[14:0];
                rfc_pkg::CFG_NEAR_DIST:   r_near_dist   <= i_cfg_data[30:0];
                rfc_pkg::CFG_MAX_FWD:     r_max_fwd     <= i_cfg_data[14:0];
                rfc_pkg::CFG_COST_GAIN:   r_cost_gain   <= i_cfg_data[30:0];
                rfc_pkg::CFG_TURN_BIAS:   r_turn_bias   <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Input stage.
    logic signed [31:0] rx, ry, sx, sy, nx, ny;
    logic signed [32:0] dx, dy, ddx, ddy;
    logic [32:0] aex, aey;
    rfc_pkg::t_side   n_s0_side, r_s0_side;
    rfc_pkg::t_cordic n_s0_cor,  r_s0_cor;
    logic signed [rfc_pkg::XW-1:0] xw, yw;

    always_comb begin
        rx  = s_axis_tdata[31:0];
        ry  = s_axis_tdata[63:32];
        sx  = s_axis_tdata[111:80];
        sy  = s_axis_tdata[143:112];
        nx  = s_axis_tdata[175:144];
        ny  = s_axis_tdata[207:176];
        dx  = 33'(nx) - 33'(sx);
        dy  = 33'(ny) - 33'(sy);
        ddx = 33'(rx) - 33'(sx);
        ddy = 33'(ry) - 33'(sy);
        aex = ddx[32] ? 33'(-ddx) : 33'(ddx);
        aey = ddy[32] ? 33'(-ddy) : 33'(ddy);
        n_s0_side          = '0;
        n_s0_side.valid    = s_axis_tvalid;
        n_s0_side.bad      = !s_axis_tuser[0] || (dx == 33'sd0 && dy == 33'sd0);
        n_s0_side.in_range = (aex[32:31] == 2'b00) && (aey[32:31] == 2'b00);
        n_s0_side.ex       = aex[30:0];
        n_s0_side.ey       = aey[30:0];
        n_s0_side.yaw      = s_axis_tdata[79:64];
        n_s0_side.fwd      = s_axis_tdata[223:208];
        n_s0_side.turn     = s_axis_tdata[239:224];
        xw = rfc_pkg::XW'(dx) <<< 20;
        yw = rfc_pkg::XW'(dy) <<< 20;
        if (dx < 0) begin
            n_s0_cor.x = -xw;
            n_s0_cor.y = -yw;
            n_s0_cor.z = (dy >= 0) ? rfc_pkg::PI_Q30 : -rfc_pkg::PI_Q30;
        end else begin
            n_s0_cor.x = xw;
            n_s0_cor.y = yw;
            n_s0_cor.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_side <= '0;
        end else if (en) begin
            r_s0_side <= n_s0_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_cor <= n_s0_cor;
        end
    end

    // CORDIC chain.
    rfc_pkg::t_side   c_side [0:CS];
    rfc_pkg::t_cordic c_cor  [0:CS];

    assign c_side[0] = r_s0_side;
    assign c_cor[0]  = r_s0_cor;

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        rfc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (rfc_pkg::STAGE_W'(i)),
            .i_side  (c_side[i]),
            .i_cor   (c_cor[i]),
            .o_side  (c_side[i+1]),
            .o_cor   (c_cor[i+1])
        );
    end

    // Heading error and squared distances.
    logic signed [rfc_pkg::ZW-1:0] zr;
    logic signed [18:0] ang, err;
    rfc_pkg::t_side n_p1_side, r_p1_side;
    logic [61:0] r_ex2, r_ey2, r_nd2;

    always_comb begin
        zr  = (c_cor[CS].z + rfc_pkg::ZW'(65536)) >>> 17;
        ang = zr[18:0];
        err = ang - 19'(c_side[CS].yaw);
        if (err > rfc_pkg::PI_Q13) begin
            err = err - rfc_pkg::TWO_PI_Q13;
        end
        if (err < -rfc_pkg::PI_Q13) begin
            err = err + rfc_pkg::TWO_PI_Q13;
        end
        n_p1_side     = c_side[CS];
        n_p1_side.err = c_side[CS].bad ? 16'sd0 : err[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_side <= '0;
        end else if (en) begin
            r_p1_side <= n_p1_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex2 <= c_side[CS].ex * c_side[CS].ex;
            r_ey2 <= c_side[CS].ey * c_side[CS].ey;
            r_nd2 <= r_near_dist * r_near_dist;
        end
    end

    // Decision and division setup.
    logic [62:0] d2;
    logic near;
    logic [15:0] abs_err, abs_fwd, abs_turn;
    rfc_pkg::t_side n_p2_side, r_p2_side;
    rfc_pkg::t_div  n_p2_div,  r_p2_div;

    always_comb begin
        d2       = 63'(r_ex2) + 63'(r_ey2);
        near     = r_p1_side.in_range && (d2 < 63'(r_nd2));
        abs_err  = r_p1_side.err[15]  ? 16'(-r_p1_side.err)  : 16'(r_p1_side.err);
        abs_fwd  = r_p1_side.fwd[15]  ? 16'(-r_p1_side.fwd)  : 16'(r_p1_side.fwd);
        abs_turn = r_p1_side.turn[15] ? 16'(-r_p1_side.turn) : 16'(r_p1_side.turn);
        n_p2_side = r_p1_side;
        if (r_p1_side.bad) begin
            n_p2_side.status = rfc_pkg::ST_NOPOSE;
        end else if (!near || abs_err <= 16'(r_angle_limit)) begin
            n_p2_side.status = rfc_pkg::ST_NONE;
        end else if (abs_fwd > 16'(r_max_fwd)
                     || (r_p1_side.turn > 0 && r_p1_side.err < 0)
                     || (r_p1_side.turn < 0 && r_p1_side.err > 0)) begin
            n_p2_side.status = rfc_pkg::ST_REJECT;
        end else begin
            n_p2_side.status = rfc_pkg::ST_SCORED;
        end
        n_p2_div.rem = '0;
        n_p2_div.den = 17'(abs_turn) + 17'(r_turn_bias);
        n_p2_div.num = {r_cost_gain, 12'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_side <= '0;
        end else if (en) begin
            r_p2_side <= n_p2_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_div <= n_p2_div;
        end
    end

    // Division chain.
    rfc_pkg::t_side d_side [0:DS];
    rfc_pkg::t_div  d_div  [0:DS];

    assign d_side[0] = r_p2_side;
    assign d_div[0]  = r_p2_div;

    for (genvar i = 0; i < DS; i++) begin : g_div
        rfc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (d_side[i]),
            .i_div   (d_div[i]),
            .o_side  (d_side[i+1]),
            .o_div   (d_div[i+1])
        );
    end

    // Output register.
    logic [31:0] cost;

    always_comb begin
        if (d_side[DS].status != rfc_pkg::ST_SCORED) begin
            cost = '0;
        end else if (|d_div[DS].num[rfc_pkg::NUM_W-1:32]) begin
            cost = 32'hFFFF_FFFF;
        end else begin
            cost = d_div[DS].num[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d_side[DS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {6'd0, d_side[DS].err, cost, d_side[DS].status};
        end
    end

    `RFC_ASSERT(a_cost_only_scored, i_clk, i_rst_n,
        !r_out_valid || r_out_data[1:0] == rfc_pkg::ST_SCORED || r_out_data[33:2] == 32'd0)
    `RFC_ASSERT(a_nopose_zero_err, i_clk, i_rst_n,
        !r_out_valid || r_out_data[1:0] != rfc_pkg::ST_NOPOSE || r_out_data[49:34] == 16'd0)
    `RFC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_s0_side.valid)

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rotate_first_trajectory_cost
// Streams pose, path and speed items through the block under several register
// settings. A local model predicts status, cost and heading error, and every
// result is compared in order with its prediction.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic               pose_valid;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] robot_yaw;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] next_x;
        logic signed [31:0] next_y;
        logic signed [15:0] fwd_speed;
        logic signed [15:0] turn_rate;
    } t_traj_item;

    typedef struct {
        logic [1:0]         status;
        logic [31:0]        cost;
        logic signed [15:0] heading_error;
    } t_traj_score;

    localparam longint ARCTAN_Q30 [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };
    localparam longint HALF_TURN_Q30 = 64'd3373259426;
    localparam longint HALF_TURN_Q13 = 25736;
    localparam int     CYCLE_LIMIT   = 400000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [239:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [55:0]  m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    rotate_first_trajectory_cost dut (.*);

    always #10 i_clk = ~i_clk;

    longint unsigned reg_angle_limit, reg_near_dist, reg_max_fwd, reg_cost_gain, reg_turn_bias;

    t_traj_item  pending_items[$];
    t_traj_score expected_scores[$];
    t_traj_item  cur_item;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    logic        hold_start = 1'b0;
    logic        no_idle = 1'b0;
    int          mismatches = 0;
    int          cycles = 0;

    function automatic t_traj_score score_trajectory(t_traj_item it);
        t_traj_score r;
        longint dx, dy, x, y, z, xs, ys, err, ex, ey, fwd, turn;
        longint unsigned d2, den, c;
        logic near;
        r.status = rfc_pkg::ST_NOPOSE;
        r.cost = '0;
        r.heading_error = '0;
        dx = longint'(it.next_x) - longint'(it.start_x);
        dy = longint'(it.next_y) - longint'(it.start_y);
        if (!it.pose_valid || (dx == 0 && dy == 0))
            return r;
        x = dx <<< 20;
        y = dy <<< 20;
        z = 0;
        if (dx < 0) begin
            z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < rfc_pkg::CORDIC_STAGES && i < rfc_pkg::ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q30[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q30[i];
            end
        end
        err = ((z + 65536) >>> 17) - longint'(it.robot_yaw);
        if (err > HALF_TURN_Q13)
            err -= 2 * HALF_TURN_Q13;
        if (err < -HALF_TURN_Q13)
            err += 2 * HALF_TURN_Q13;
        ex = longint'(it.robot_x) - longint'(it.start_x);
        ey = longint'(it.robot_y) - longint'(it.start_y);
        ex = (ex < 0) ? -ex : ex;
        ey = (ey < 0) ? -ey : ey;
        near = 1'b0;
        if (ex < 64'sd2147483648 && ey < 64'sd2147483648) begin
            d2 = ex * ex + ey * ey;
            near = d2 < reg_near_dist * reg_near_dist;
        end
        fwd = longint'(it.fwd_speed);
        turn = longint'(it.turn_rate);
        r.heading_error = err[15:0];
        if (!near || longint'(err < 0 ? -err : err) <= longint'(reg_angle_limit)) begin
            r.status = rfc_pkg::ST_NONE;
        end else if ((fwd < 0 ? -fwd : fwd) > longint'(reg_max_fwd) ||
                     (turn > 0 && err < 0) || (turn < 0 && err > 0)) begin
            r.status = rfc_pkg::ST_REJECT;
        end else begin
            r.status = rfc_pkg::ST_SCORED;
            den = longint'(turn < 0 ? -turn : turn) + reg_turn_bias;
            if (den == 0) begin
                r.cost = 32'hFFFF_FFFF;
            end else begin
                c = (reg_cost_gain << 12) / den;
                r.cost = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        logic nvalid;
        nvalid = s_axis_tvalid;
        if (!i_rst_n) begin
            nvalid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_scores.push_back(score_trajectory(cur_item));
                nvalid = 1'b0;
            end
            if (!nvalid) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tuser <= cur_item.pose_valid;
                    s_axis_tdata <= {cur_item.turn_rate, cur_item.fwd_speed, cur_item.next_y,
                                     cur_item.next_x, cur_item.start_y, cur_item.start_x,
                                     cur_item.robot_yaw, cur_item.robot_y, cur_item.robot_x};
                    nvalid = 1'b1;
                    send_gap <= no_idle ? 0 : int'($urandom_range(0, 3));
                end
            end
        end
        s_axis_tvalid <= nvalid;
    end

    always @(posedge i_clk) begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        t_traj_score want;
        logic [1:0]  got_status;
        logic [31:0] got_cost;
        logic [15:0] got_err;
        int          gap;
        gap = recv_gap;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status = m_axis_tdata[1:0];
            got_cost = m_axis_tdata[33:2];
            got_err = m_axis_tdata[49:34];
            if (expected_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d cost %h error %h",
                             got_status, got_cost, got_err);
            end else begin
                want = expected_scores.pop_front();
                if (got_status !== want.status || got_cost !== want.cost ||
                    got_err !== want.heading_error || m_axis_tdata[55:50] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d/%h/%h, got %0d/%h/%h (fill %h)",
                                 want.status, want.cost, want.heading_error,
                                 got_status, got_cost, got_err, m_axis_tdata[55:50]);
                end
            end
            gap = no_idle ? 0 : int'($urandom_range(0, 3));
        end else if (gap > 0) begin
            gap--;
        end
        recv_gap <= gap;
        m_axis_tready <= i_rst_n && gap == 0 && hold_left == 0 && !hold_start;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rfc_pkg::CFG_ANGLE_LIMIT: reg_angle_limit = value & 32'h7FFF;
            rfc_pkg::CFG_NEAR_DIST:   reg_near_dist = value & 32'h7FFF_FFFF;
            rfc_pkg::CFG_MAX_FWD:     reg_max_fwd = value & 32'h7FFF;
            rfc_pkg::CFG_COST_GAIN:   reg_cost_gain = value & 32'h7FFF_FFFF;
            rfc_pkg::CFG_TURN_BIAS:   reg_turn_bias = value & 32'h7FFF;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_scores.size() > 0)
            @(negedge i_clk);
        repeat (rfc_pkg::CORDIC_STAGES + 60) @(posedge i_clk);
    endtask

    function automatic t_traj_item random_item();
        t_traj_item it;
        int span;
        it.pose_valid = ($urandom_range(0, 19) != 0);
        it.start_x = $urandom;
        it.start_y = $urandom;
        it.next_x = $urandom_range(0, 3) == 0 ? $urandom :
                    it.start_x + $signed($urandom_range(0, 200000)) - 100000;
        it.next_y = $urandom_range(0, 3) == 0 ? $urandom :
                    it.start_y + $signed($urandom_range(0, 200000)) - 100000;
        span = (reg_near_dist > 1000000) ? 1000000 : int'(reg_near_dist) + 1;
        if ($urandom_range(0, 4) == 0) begin
            it.robot_x = $urandom;
            it.robot_y = $urandom;
        end else begin
            it.robot_x = it.start_x + $signed($urandom_range(0, 2 * span)) - span;
            it.robot_y = it.start_y + $signed($urandom_range(0, 2 * span)) - span;
        end
        it.robot_yaw = 16'($urandom);
        it.fwd_speed = $urandom_range(0, 1) ? 16'($urandom) :
                       16'($signed($urandom_range(0, 800)) - 400);
        it.turn_rate = $urandom_range(0, 7) == 0 ? 16'sd0 : 16'($urandom);
        if ($urandom_range(0, 29) == 0)
            it.next_x = it.start_x;
        if ($urandom_range(0, 29) == 0)
            it.next_y = it.start_y;
        return it;
    endfunction

    initial begin
        t_traj_item it;
        reg_angle_limit = 16384;
        reg_near_dist = 13107;
        reg_max_fwd = 287;
        reg_cost_gain = 655360;
        reg_turn_bias = 819;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // Directed items: extremes, missing pose, degenerate path, far robot.
        it = '{1'b1, 0, 0, 16'sd0, 0, 0, 32'sd65536, 0, 16'sd0, 16'sd0};
        for (int k = 0; k < 24; k++) begin
            it.robot_yaw = (k % 4 == 0) ? -16'sd32768 : (k % 4 == 1) ? 16'sd32767 :
                           (k % 4 == 2) ? 16'sd25736 : -16'sd25736;
            it.fwd_speed = (k % 3 == 0) ? -16'sd32768 : (k % 3 == 1) ? 16'sd32767 : 16'sd0;
            it.turn_rate = (k % 5 == 0) ? -16'sd32768 : (k % 5 == 1) ? 16'sd32767 :
                           (k % 5 == 2) ? 16'sd0 : (k % 5 == 3) ? 16'sd100 : -16'sd100;
            it.next_x = (k % 6 < 3) ? -32'sd65536 : 32'sd65536;
            it.next_y = (k % 2) ? 32'sd1000 : -32'sd1000;
            it.robot_x = 0;
            it.start_x = 0;
            it.start_y = 0;
            it.pose_valid = (k != 7);
            if (k == 9) begin
                it.next_x = 0;
                it.next_y = 0;
            end
            if (k == 10) begin
                it.start_x = 32'h8000_0000;
                it.next_x = 32'h7FFF_FFFF;
                it.robot_x = 32'h7FFF_FFFF;
            end
            if (k == 11) begin
                it.start_y = 32'h7FFF_FFFF;
                it.next_y = 32'h8000_0000;
            end
            pending_items.push_back(it);
        end
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                1: begin
                    write_reg(rfc_pkg::CFG_ANGLE_LIMIT, 0);
                    write_reg(rfc_pkg::CFG_NEAR_DIST, 32'h7FFF_FFFF);
                    write_reg(rfc_pkg::CFG_MAX_FWD, 32'h7FFF);
                    write_reg(rfc_pkg::CFG_COST_GAIN, 32'h7FFF_FFFF);
                    write_reg(rfc_pkg::CFG_TURN_BIAS, 0);
                end
                2: begin
                    write_reg(rfc_pkg::CFG_ANGLE_LIMIT, 25736);
                    write_reg(rfc_pkg::CFG_NEAR_DIST, 0);
                    write_reg(rfc_pkg::CFG_MAX_FWD, 0);
                    write_reg(rfc_pkg::CFG_COST_GAIN, 0);
                    write_reg(rfc_pkg::CFG_TURN_BIAS, 32'h7FFF);
                end
                3: begin
                    write_reg(rfc_pkg::CFG_ANGLE_LIMIT, 0);
                    write_reg(rfc_pkg::CFG_NEAR_DIST, 32'h7FFF_FFFF);
                    write_reg(rfc_pkg::CFG_MAX_FWD, 0);
                    write_reg(rfc_pkg::CFG_COST_GAIN, 655360);
                    write_reg(rfc_pkg::CFG_TURN_BIAS, 1);
                    write_reg(3'd5, $urandom);
                    write_reg(3'd7, $urandom);
                end
                0: ;
                default: begin
                    write_reg(rfc_pkg::CFG_ANGLE_LIMIT, $urandom_range(0, 25736));
                    write_reg(rfc_pkg::CFG_NEAR_DIST, $urandom_range(0, 1) ?
                              $urandom_range(0, 200000) : $urandom_range(0, 32'h7FFF_FFFF));
                    write_reg(rfc_pkg::CFG_MAX_FWD, $urandom_range(0, 32767));
                    write_reg(rfc_pkg::CFG_COST_GAIN, $urandom_range(0, 32'h7FFF_FFFF));
                    write_reg(rfc_pkg::CFG_TURN_BIAS, $urandom_range(0, 3) == 0 ?
                              0 : $urandom_range(0, 32767));
                    write_reg(3'd6, $urandom);
                end
            endcase
            no_idle <= (ph == 4);
            for (int n = 0; n < 100; n++) begin
                pending_items.push_back(random_item());
                if (n == 40 && (ph == 2 || ph == 5))
                    hold_start <= 1'b1;
                if (n == 41)
                    hold_start <= 1'b0;
                if (n % 10 == 0)
                    @(posedge i_clk);
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_scores.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
